// ===== hw/rtl/hslp_pkg.sv =====
// hslp_pkg: shared types and constants for the http status line parser
// no dependencies; imported by every other rtl file of the block
`default_nettype none

package hslp_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_LEADING_SPACE = 2'd0,
        CFG_MAX_STATUS_VALUE  = 2'd1,
        CFG_MAX_REASON_BYTES  = 2'd2,
        CFG_STRICT_LINE_END   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_WS     = 3'd1,
        ERR_STATUS = 3'd2,
        ERR_REASON = 3'd3,
        ERR_EOL    = 3'd4
    } t_err;

    typedef enum logic [17:0] {
        PH_H          = 18'h00001,
        PH_T1         = 18'h00002,
        PH_T2         = 18'h00004,
        PH_P          = 18'h00008,
        PH_SLASH      = 18'h00010,
        PH_MAJOR      = 18'h00020,
        PH_DOT        = 18'h00040,
        PH_MINOR      = 18'h00080,
        PH_WS         = 18'h00100,
        PH_STATUS     = 18'h00200,
        PH_REASON     = 18'h00400,
        PH_LF         = 18'h00800,
        PH_VALID      = 18'h01000,
        PH_DEAD       = 18'h02000,
        PH_ERR_WS     = 18'h04000,
        PH_ERR_STATUS = 18'h08000,
        PH_ERR_REASON = 18'h10000,
        PH_ERR_EOL    = 18'h20000
    } t_phase;

    typedef struct packed {
        logic [7:0]  max_leading_space;
        logic [15:0] max_status_value;
        logic [15:0] max_reason_bytes;
        logic        strict_line_end;
    } t_cfg;

    typedef struct packed {
        logic       restart;
        logic [7:0] in_byte;
    } t_in_word;

    typedef struct packed {
        logic        accepted;
        logic        line_complete;
        logic [2:0]  error_code;
        logic [3:0]  major_digit;
        logic [3:0]  minor_digit;
        logic [15:0] status_code;
        logic        reason_valid;
        logic [7:0]  reason_byte;
    } t_out_word;

endpackage

`default_nettype wire

// ===== hw/rtl/hslp_ifs.sv =====
// hslp_in_if / hslp_out_if: valid-ready channels for input and result words
// depends on hslp_pkg for the word types
`default_nettype none

interface hslp_in_if
    import hslp_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hslp_out_if
    import hslp_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/http_status_line_parser.sv =====
// http_status_line_parser: top level, input word register, step core, result register
// depends on hslp_pkg, hslp_ifs, hslp_cfg_regs, hslp_core
//
//   channel  dir  word fields                                   handshake
//   i_in     in   restart, in_byte                              valid/ready
//   o_out    out  accepted, line_complete, error_code, digits,  valid/ready
//                 status_code, reason_valid, reason_byte
//   cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data               write only
//
// one byte per cycle while the result register is not stalled; an accepted byte waits in the input register,
// then the state step and result capture happen in the same cycle
// result valid rises when the result register captures the stepped byte
// synchronous active-low reset restores the limits and the parse state
// a stalled result register holds the byte in the input register; no state moves
`default_nettype none

module http_status_line_parser
    import hslp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    hslp_in_if.sink                    i_in,
    hslp_out_if.source                 o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    logic      step;
    logic      in_take;
    t_cfg      cfg;
    t_out_word result;

    assign step        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || step;
    assign in_take     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    hslp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    hslp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (r_in_word),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) r_in_valid <= 1'b1;
            else if (step) r_in_valid <= 1'b0;
            if (step) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) r_in_word <= i_in.data;
        if (step) r_out_word <= result;
    end

    // a byte in reason output must have been accepted
    a_reason_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_word.reason_valid |-> r_out_word.accepted)
        else $error("reason byte on a rejected word");

    // an error word never accepts and never completes
    a_err_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_word.error_code != ERR_NONE)
        |-> !r_out_word.accepted && !r_out_word.line_complete)
        else $error("error word accepted or complete");

    // a stepped byte always lands in the result register
    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("stepped byte lost");

endmodule

`default_nettype wire

// ===== hw/rtl/hslp_cfg_regs.sv =====
// hslp_cfg_regs: limit and mode registers behind a plain write port
// depends on hslp_pkg
`default_nettype none

module hslp_cfg_regs
    import hslp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_leading_space <= 8'd8;
            r_cfg.max_status_value  <= 16'd65534;
            r_cfg.max_reason_bytes  <= 16'd65534;
            r_cfg.strict_line_end   <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_LEADING_SPACE: r_cfg.max_leading_space <= i_cfg_data[7:0];
                CFG_MAX_STATUS_VALUE:  r_cfg.max_status_value  <= i_cfg_data;
                CFG_MAX_REASON_BYTES:  r_cfg.max_reason_bytes  <= i_cfg_data;
                CFG_STRICT_LINE_END:   r_cfg.strict_line_end   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hw/rtl/hslp_core.sv =====
// hslp_core: parse state registers and the one-byte step logic
// depends on hslp_pkg; result is combinational, registered by the top level
`default_nettype none

module hslp_core
    import hslp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire t_in_word i_word,
    input  wire t_cfg     i_cfg,
    output t_out_word     o_result
);

    t_phase      r_phase,  n_phase,  b_phase;
    logic [8:0]  r_space,  n_space,  b_space;
    logic        r_seen,   n_seen,   b_seen;
    logic [19:0] r_accum,  n_accum,  b_accum;
    logic [3:0]  r_major,  n_major,  b_major;
    logic [3:0]  r_minor,  n_minor,  b_minor;
    logic [16:0] r_rcount, n_rcount, b_rcount;

    logic [7:0]  c;
    logic        is_blank, is_digit, acc, rv, mismatch;
    logic [8:0]  space_inc;
    logic [19:0] accum_mul;
    logic [16:0] rcount_inc;
    t_err        err;

    always_comb begin
        c        = i_word.in_byte;
        is_blank = c inside {CH_SP, CH_TAB};
        is_digit = c inside {[CH_ZERO:CH_NINE]};

        // restart clears parse state ahead of this byte
        b_phase  = i_word.restart ? PH_H  : r_phase;
        b_space  = i_word.restart ? '0    : r_space;
        b_seen   = i_word.restart ? 1'b0  : r_seen;
        b_accum  = i_word.restart ? '0    : r_accum;
        b_major  = i_word.restart ? '0    : r_major;
        b_minor  = i_word.restart ? '0    : r_minor;
        b_rcount = i_word.restart ? '0    : r_rcount;

        space_inc  = b_space + 9'd1;
        accum_mul  = {b_accum[16:0], 3'b000} + {b_accum[18:0], 1'b0} + {16'd0, c[3:0]};
        rcount_inc = b_rcount + 17'd1;

        n_phase  = b_phase;
        n_space  = b_space;
        n_seen   = b_seen;
        n_accum  = b_accum;
        n_major  = b_major;
        n_minor  = b_minor;
        n_rcount = b_rcount;
        acc      = 1'b0;
        rv       = 1'b0;
        mismatch = 1'b0;

        case (b_phase)
            PH_H: begin
                if (is_blank) begin
                    n_space = space_inc;
                    if (space_inc > {1'b0, i_cfg.max_leading_space}) n_phase = PH_ERR_WS;
                    else acc = 1'b1;
                end else if (c == CH_H) begin
                    n_phase = PH_T1;
                    acc     = 1'b1;
                end else begin
                    mismatch = 1'b1;
                end
            end
            PH_T1: begin
                if (c == CH_T) begin
                    n_phase = PH_T2;
                    acc     = 1'b1;
                end else mismatch = 1'b1;
            end
            PH_T2: begin
                if (c == CH_T) begin
                    n_phase = PH_P;
                    acc     = 1'b1;
                end else mismatch = 1'b1;
            end
            PH_P: begin
                if (c == CH_P) begin
                    n_phase = PH_SLASH;
                    acc     = 1'b1;
                end else mismatch = 1'b1;
            end
            PH_SLASH: begin
                if (c == CH_SLASH) begin
                    n_phase = PH_MAJOR;
                    acc     = 1'b1;
                end else mismatch = 1'b1;
            end
            PH_MAJOR: begin
                if (is_digit) begin
                    n_major = c[3:0];
                    n_phase = PH_DOT;
                    acc     = 1'b1;
                end else mismatch = 1'b1;
            end
            PH_DOT: begin
                if (c == CH_DOT) begin
                    n_phase = PH_MINOR;
                    acc     = 1'b1;
                end else mismatch = 1'b1;
            end
            PH_MINOR: begin
                if (is_digit) begin
                    n_minor = c[3:0];
                    n_phase = PH_WS;
                    acc     = 1'b1;
                end else mismatch = 1'b1;
            end
            PH_WS: begin
                if (is_blank) begin
                    n_space = 9'd1;
                    n_phase = PH_STATUS;
                    acc     = 1'b1;
                end else mismatch = 1'b1;
            end
            PH_STATUS: begin
                if (is_digit) begin
                    n_seen  = 1'b1;
                    n_accum = accum_mul;
                    if (accum_mul > {4'd0, i_cfg.max_status_value}) n_phase = PH_ERR_STATUS;
                    else acc = 1'b1;
                end else if (is_blank && b_seen) begin
                    n_space = 9'd1;
                    n_phase = PH_REASON;
                    acc     = 1'b1;
                end else if (is_blank) begin
                    n_space = space_inc;
                    if (space_inc > {1'b0, i_cfg.max_leading_space}) n_phase = PH_ERR_WS;
                    else acc = 1'b1;
                end else begin
                    mismatch = 1'b1;
                end
            end
            PH_REASON: begin
                if (c == CH_CR) begin
                    n_phase = PH_LF;
                    acc     = 1'b1;
                end else if (c == CH_LF) begin
                    if (i_cfg.strict_line_end) begin
                        n_phase = PH_ERR_EOL;
                    end else begin
                        n_phase = PH_VALID;
                        acc     = 1'b1;
                    end
                end else if (b_rcount == '0 && is_blank) begin
                    n_space = space_inc;
                    if (space_inc > {1'b0, i_cfg.max_leading_space}) n_phase = PH_ERR_WS;
                    else acc = 1'b1;
                end else begin
                    n_rcount = rcount_inc;
                    if (rcount_inc > {1'b0, i_cfg.max_reason_bytes}) begin
                        n_phase = PH_ERR_REASON;
                    end else begin
                        acc = 1'b1;
                        rv  = 1'b1;
                    end
                end
            end
            PH_LF: begin
                if (c == CH_LF) begin
                    n_phase = PH_VALID;
                    acc     = 1'b1;
                end else mismatch = 1'b1;
            end
            default: begin
            end
        endcase

        if (mismatch) n_phase = PH_DEAD;

        case (n_phase)
            PH_ERR_WS:     err = ERR_WS;
            PH_ERR_STATUS: err = ERR_STATUS;
            PH_ERR_REASON: err = ERR_REASON;
            PH_ERR_EOL:    err = ERR_EOL;
            default:       err = ERR_NONE;
        endcase

        o_result.accepted      = acc;
        o_result.line_complete = (n_phase == PH_VALID);
        o_result.error_code    = err;
        o_result.major_digit   = n_major;
        o_result.minor_digit   = n_minor;
        o_result.status_code   = (|n_accum[19:16]) ? 16'hFFFF : n_accum[15:0];
        o_result.reason_valid  = rv;
        o_result.reason_byte   = rv ? c : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_H;
            r_space  <= '0;
            r_seen   <= 1'b0;
            r_accum  <= '0;
            r_major  <= '0;
            r_minor  <= '0;
            r_rcount <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_space  <= n_space;
            r_seen   <= n_seen;
            r_accum  <= n_accum;
            r_major  <= n_major;
            r_minor  <= n_minor;
            r_rcount <= n_rcount;
        end
    end

endmodule

`default_nettype wire

// ===== dv/hslp_checker.sv =====
`timescale 1ns / 100ps
// hslp_checker: predicts every result word of the status line parser and compares it
// watches the input, output and register write ports; depends on hslp_pkg

module hslp_checker
    import hslp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire t_in_word              i_in_word,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire t_out_word             i_out_word,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [31:0]                o_fail_count,
    output logic [15:0]                o_pending
);

    t_cfg        limits;
    t_phase      phase;
    logic [8:0]  blank_cnt;
    logic        code_seen;
    logic [19:0] code_acc;
    logic [3:0]  major_q;
    logic [3:0]  minor_q;
    logic [16:0] reason_len;
    t_out_word   line_results_q[$];
    int unsigned fails;

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SP || c == CH_TAB;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void clear_line();
        phase      = PH_H;
        blank_cnt  = '0;
        code_seen  = 1'b0;
        code_acc   = '0;
        major_q    = '0;
        minor_q    = '0;
        reason_len = '0;
    endfunction

    function automatic logic bump_blank();
        blank_cnt = blank_cnt + 9'd1;
        if (blank_cnt > {1'b0, limits.max_leading_space}) begin
            phase = PH_ERR_WS;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic advance_on(logic hit, t_phase nxt);
        if (hit) begin
            phase = nxt;
            return 1'b1;
        end
        phase = PH_DEAD;
        return 1'b0;
    endfunction

    function automatic t_out_word step_line(t_in_word w);
        t_out_word  r;
        logic [7:0] c;
        logic       ok;
        logic       to_reason;
        c         = w.in_byte;
        ok        = 1'b0;
        to_reason = 1'b0;
        if (w.restart)
            clear_line();
        case (phase)
            PH_H: begin
                if (is_blank(c))
                    ok = bump_blank();
                else
                    ok = advance_on(c == CH_H, PH_T1);
            end
            PH_T1:    ok = advance_on(c == CH_T, PH_T2);
            PH_T2:    ok = advance_on(c == CH_T, PH_P);
            PH_P:     ok = advance_on(c == CH_P, PH_SLASH);
            PH_SLASH: ok = advance_on(c == CH_SLASH, PH_MAJOR);
            PH_MAJOR: begin
                if (is_digit(c))
                    major_q = c[3:0];
                ok = advance_on(is_digit(c), PH_DOT);
            end
            PH_DOT:   ok = advance_on(c == CH_DOT, PH_MINOR);
            PH_MINOR: begin
                if (is_digit(c))
                    minor_q = c[3:0];
                ok = advance_on(is_digit(c), PH_WS);
            end
            PH_WS: begin
                if (is_blank(c))
                    blank_cnt = 9'd1;
                ok = advance_on(is_blank(c), PH_STATUS);
            end
            PH_STATUS: begin
                if (is_digit(c)) begin
                    code_seen = 1'b1;
                    code_acc  = code_acc * 20'd10 + 20'(c[3:0]);
                    ok        = code_acc <= 20'(limits.max_status_value);
                    if (!ok)
                        phase = PH_ERR_STATUS;
                end else if (is_blank(c) && code_seen) begin
                    blank_cnt = 9'd1;
                    ok        = advance_on(1'b1, PH_REASON);
                end else if (is_blank(c)) begin
                    ok = bump_blank();
                end else begin
                    phase = PH_DEAD;
                end
            end
            PH_REASON: begin
                if (c == CH_CR) begin
                    ok = advance_on(1'b1, PH_LF);
                end else if (c == CH_LF && !limits.strict_line_end) begin
                    ok = advance_on(1'b1, PH_VALID);
                end else if (c == CH_LF) begin
                    phase = PH_ERR_EOL;
                end else if (reason_len == '0 && is_blank(c)) begin
                    ok = bump_blank();
                end else begin
                    reason_len = reason_len + 17'd1;
                    ok         = reason_len <= 17'(limits.max_reason_bytes);
                    to_reason  = ok;
                    if (!ok)
                        phase = PH_ERR_REASON;
                end
            end
            PH_LF:   ok = advance_on(c == CH_LF, PH_VALID);
            default: ok = 1'b0;
        endcase

        r.accepted      = ok;
        r.line_complete = phase == PH_VALID;
        case (phase)
            PH_ERR_WS:     r.error_code = ERR_WS;
            PH_ERR_STATUS: r.error_code = ERR_STATUS;
            PH_ERR_REASON: r.error_code = ERR_REASON;
            PH_ERR_EOL:    r.error_code = ERR_EOL;
            default:       r.error_code = ERR_NONE;
        endcase
        r.major_digit  = major_q;
        r.minor_digit  = minor_q;
        r.status_code  = (code_acc > 20'hFFFF) ? 16'hFFFF : code_acc[15:0];
        r.reason_valid = to_reason;
        r.reason_byte  = to_reason ? c : 8'h00;
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            limits = {8'd8, 16'd65534, 16'd65534, 1'b0};
            clear_line();
            line_results_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MAX_LEADING_SPACE: limits.max_leading_space = i_cfg_data[7:0];
                    CFG_MAX_STATUS_VALUE:  limits.max_status_value  = i_cfg_data;
                    CFG_MAX_REASON_BYTES:  limits.max_reason_bytes  = i_cfg_data;
                    CFG_STRICT_LINE_END:   limits.strict_line_end   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                line_results_q.insert(line_results_q.size(), step_line(i_in_word));
            if (i_out_valid && i_out_ready) begin
                if (line_results_q.size() == 0) begin
                    $error("result word arrived with no expectation pending");
                    fails++;
                end else begin
                    want = line_results_q.pop_front();
                    check_field("accepted", want.accepted, i_out_word.accepted);
                    check_field("line_complete", want.line_complete, i_out_word.line_complete);
                    check_field("error_code", want.error_code, i_out_word.error_code);
                    check_field("major_digit", want.major_digit, i_out_word.major_digit);
                    check_field("minor_digit", want.minor_digit, i_out_word.minor_digit);
                    check_field("status_code", want.status_code, i_out_word.status_code);
                    check_field("reason_valid", want.reason_valid, i_out_word.reason_valid);
                    check_field("reason_byte", want.reason_byte, i_out_word.reason_byte);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= 16'(line_results_q.size());
    end

endmodule

// ===== dv/tb_http_status_line_parser.sv =====
`timescale 1ns / 100ps
// tb_http_status_line_parser: feeds status lines, noise and broken lines under random stalls
// depends on hslp_pkg, hslp_ifs, the parser rtl and hslp_checker, which predicts and compares

module tb_http_status_line_parser;
    import hslp_pkg::*;

    localparam int    CLK_HALF     = 2;
    localparam int    STALL_CYCLES = 200;
    // longest quiet stretch is the receiver hold-off plus a drain
    localparam int    QUIET_LIMIT  = 2000;
    localparam string PROTO_TAG    = "HTTP/";

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic [31:0]           fail_count;
    logic [15:0]           pending_words;
    int unsigned           send_idle_pct = 20;
    int unsigned           recv_idle_pct = 58;
    logic                  hold_req      = 1'b0;
    int unsigned           quiet_cycles  = 0;
    t_in_word              line_bytes[$];

    hslp_in_if  in_ch ();
    hslp_out_if out_ch ();

    http_status_line_parser uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    hslp_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_word    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_word   (out_ch.data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    initial begin
        forever #(CLK_HALF) clk = ~clk;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_word(t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    task automatic send_text(string s, logic first_restart);
        t_in_word w;
        for (int i = 0; i < s.len(); i++) begin
            w.restart = (i == 0) && first_restart;
            w.in_byte = s[i];
            push_word(w);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // limit sets: two opposite extreme sets, then small random limits
    task automatic program_limits(int unsigned kind);
        logic [7:0]  spaces;
        logic [15:0] code_max;
        logic [15:0] reason_max;
        logic        strict;
        case (kind)
            0: begin
                spaces     = 8'd0;
                code_max   = 16'hFFFF;
                reason_max = 16'hFFFF;
                strict     = 1'b1;
            end
            1: begin
                spaces     = 8'd255;
                code_max   = 16'd0;
                reason_max = 16'd0;
                strict     = 1'b0;
            end
            default: begin
                spaces     = 8'($urandom_range(1, 4));
                code_max   = 16'($urandom_range(100, 999));
                reason_max = 16'($urandom_range(2, 12));
                strict     = 1'($urandom_range(1));
            end
        endcase
        write_reg(CFG_MAX_LEADING_SPACE, {8'($urandom), spaces});
        write_reg(CFG_MAX_STATUS_VALUE, code_max);
        write_reg(CFG_MAX_REASON_BYTES, reason_max);
        write_reg(CFG_STRICT_LINE_END, {15'($urandom), strict});
    endtask

    function automatic void add_byte(logic [7:0] b);
        line_bytes.insert(line_bytes.size(), {1'b0, b});
    endfunction

    function automatic logic [7:0] pick_blank();
        return $urandom_range(1) ? CH_SP : CH_TAB;
    endfunction

    function automatic logic [7:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    task automatic build_line();
        int unsigned shape;
        int unsigned n;
        logic [7:0]  b;
        line_bytes.delete();
        shape = $urandom_range(99);
        if (shape < 10) begin
            n = $urandom_range(1, 12);
            repeat (n) add_byte(8'($urandom_range(255)));
        end else begin
            n = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
            repeat (n) add_byte(pick_blank());
            for (int i = 0; i < PROTO_TAG.len(); i++)
                add_byte(PROTO_TAG[i]);
            add_byte(pick_digit());
            add_byte(CH_DOT);
            add_byte(pick_digit());
            n = $urandom_range(1, 3);
            repeat (n) add_byte(pick_blank());
            n = $urandom_range(1, 5);
            repeat (n) add_byte(($urandom_range(9) < 3) ? CH_ZERO : pick_digit());
            n = $urandom_range(1, 2);
            repeat (n) add_byte(pick_blank());
            n = ($urandom_range(4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
            repeat (n) begin
                b = 8'($urandom_range(255));
                add_byte((b == CH_CR || b == CH_LF) ? CH_SP : b);
            end
            shape = $urandom_range(9);
            if (shape < 6) begin
                add_byte(CH_CR);
                add_byte(CH_LF);
            end else if (shape < 8) begin
                add_byte(CH_LF);
            end else if (shape == 8) begin
                add_byte(CH_CR);
                add_byte(8'($urandom_range(255)));
            end
            // broken lines: one byte replaced, junk after the line end, or both
            if ($urandom_range(99) < 20)
                line_bytes[$urandom_range(line_bytes.size() - 1)].in_byte = 8'($urandom_range(255));
            if ($urandom_range(4) == 0) begin
                n = $urandom_range(1, 3);
                repeat (n) add_byte(8'($urandom_range(255)));
            end
        end
        line_bytes[0].restart = 1'b1;
        if ($urandom_range(9) == 0)
            line_bytes[$urandom_range(line_bytes.size() - 1)].restart = 1'b1;
    endtask

    task automatic send_lines(int unsigned target);
        int unsigned sent;
        sent = 0;
        while (sent < target) begin
            build_line();
            foreach (line_bytes[i])
                push_word(line_bytes[i]);
            sent += line_bytes.size();
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        cfg_we      = 1'b0;
        cfg_idx     = '0;
        cfg_data    = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset limits: bare lf end, word after completion, status above the maximum
        send_text("HTTP/9.0\t0 ", 1'b1);
        push_word({1'b0, CH_LF});
        push_word({1'b0, 8'h80});
        send_text("HTTP/0.9 65535", 1'b1);

        for (int g = 0; g < 9; g++) begin
            case (g / 3)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 58;
                end
                1: begin
                    send_idle_pct = 58;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            drain_results();
            program_limits(g % 3);
            if (g == 6)
                hold_req = 1'b1;
            send_lines(33);
        end
        drain_results();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
